// ===== hdl/vws_pkg.sv =====
// vws_pkg: payload structs, register indexes and constants for vertex_wetness_splat
// no dependencies
package vws_pkg;

    localparam int unsigned MAX_VERTS  = 4096;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned WET_W      = 17;
    localparam logic [16:0] WET_ONE    = 17'd65536;
    localparam logic [12:0] SHADE_ONE  = 13'd4096;

    localparam logic [2:0] REG_HIT_X     = 3'd0;
    localparam logic [2:0] REG_HIT_Y     = 3'd1;
    localparam logic [2:0] REG_HIT_Z     = 3'd2;
    localparam logic [2:0] REG_RANGE     = 3'd3;
    localparam logic [2:0] REG_INV_RANGE = 3'd4;
    localparam logic [2:0] REG_MIN_COLOR = 3'd5;
    localparam logic [2:0] REG_INTENSITY = 3'd6;

    typedef struct packed {
        logic        [11:0] vertex_index;
        logic signed [23:0] vertex_x;
        logic signed [23:0] vertex_y;
        logic signed [23:0] vertex_z;
    } vws_in_t;

    typedef struct packed {
        logic [11:0] out_index;
        logic [16:0] wetness_level;
        logic [12:0] shade_level;
    } vws_out_t;

endpackage

// ===== hdl/vws_isqrt.sv =====
// vws_isqrt: pipelined floor square root, two result bits per stage
// depends on nothing; used by vertex_wetness_splat
module vws_isqrt #(
    parameter int unsigned IN_W = 52,
    parameter int unsigned TAG_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_value,
    input  logic [TAG_W-1:0]    in_tag,
    input  logic                advance,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [TAG_W-1:0]    out_tag
);
    localparam int unsigned RW = IN_W / 2;
    localparam int unsigned STAGES = RW / 2;

    logic                     vld_reg  [STAGES+1];
    logic [IN_W-1:0]          rem_reg  [STAGES+1];
    logic [IN_W-1:0]          src_reg  [STAGES+1];
    logic [RW-1:0]            root_reg [STAGES+1];
    logic [TAG_W-1:0]         tag_reg  [STAGES+1];

    always_comb
    begin
        rem_reg[0]  = '0;
        src_reg[0]  = in_value;
        root_reg[0] = '0;
        tag_reg[0]  = in_tag;
        vld_reg[0]  = in_valid;
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [IN_W-1:0] rem_n;
        logic [IN_W-1:0] src_n;
        logic [RW-1:0]   root_n;
        always_comb
        begin
            logic [IN_W+1:0] r;
            logic [IN_W+1:0] t;
            r = {2'b00, rem_reg[s]};
            root_n = root_reg[s];
            src_n = src_reg[s];
            for (int k = 0; k < 2; k++)
            begin
                r = {r[IN_W-1:0], src_n[IN_W-1:IN_W-2]};
                src_n = {src_n[IN_W-3:0], 2'b00};
                t = {{(IN_W+2-RW-2){1'b0}}, root_n, 2'b01};
                if (r >= t)
                begin
                    r = r - t;
                    root_n = {root_n[RW-2:0], 1'b1};
                end
                else
                begin
                    root_n = {root_n[RW-2:0], 1'b0};
                end
            end
            rem_n = r[IN_W-1:0];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s+1]  <= rem_n;
                src_reg[s+1]  <= src_n;
                root_reg[s+1] <= root_n;
                tag_reg[s+1]  <= tag_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign out_root  = root_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];

endmodule

// ===== hdl/vertex_wetness_splat.sv =====
// vertex_wetness_splat: per-vertex wetness accumulation and shade for a splash hit
// depends on vws_pkg and vws_isqrt
// a request passes stages 1 to 3, the square-root stages and stages 4 to 7; one vertex per cycle when not stalled
// the whole pipeline stalls while a result waits; one read and one write of the wetness
// memory per cycle, with forwarding for repeated vertices
// reset: after rst_n rises a clearing pass sweeps all MAX_VERTS entries of the wetness
// memory; no request is taken until it ends; configuration writes are taken at once
module vertex_wetness_splat (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  vws_pkg::vws_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output vws_pkg::vws_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [vws_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vws_pkg::CFG_DATA_W-1:0]      cfg_data
);
    localparam int unsigned MAX_VERTS = vws_pkg::MAX_VERTS;
    localparam int unsigned AW = $clog2(MAX_VERTS);
    localparam int unsigned SQ_W = 52;
    localparam int unsigned TAG_W = 12 + 1;

    logic signed [23:0] hit_x_reg, hit_y_reg, hit_z_reg;
    logic [22:0] range_reg;
    logic [31:0] inv_reg;
    logic [12:0] min_color_reg;
    logic [16:0] intensity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_x_reg <= '0;
            hit_y_reg <= '0;
            hit_z_reg <= '0;
            range_reg <= 23'd256;
            inv_reg <= 32'd16777216;
            min_color_reg <= 13'd409;
            intensity_reg <= 17'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vws_pkg::REG_HIT_X:     hit_x_reg <= cfg_data[23:0];
                vws_pkg::REG_HIT_Y:     hit_y_reg <= cfg_data[23:0];
                vws_pkg::REG_HIT_Z:     hit_z_reg <= cfg_data[23:0];
                vws_pkg::REG_RANGE:     range_reg <= cfg_data[22:0];
                vws_pkg::REG_INV_RANGE: inv_reg <= cfg_data;
                vws_pkg::REG_MIN_COLOR: min_color_reg <= cfg_data[12:0];
                vws_pkg::REG_INTENSITY: intensity_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // clearing pass
    logic [AW:0] clr_cnt_reg;
    logic clearing;
    assign clearing = (clr_cnt_reg != MAX_VERTS[AW:0]);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // pipeline stall: whole pipe moves when output slot frees
    logic advance;
    logic s7_valid_reg;
    assign advance = !s7_valid_reg || out_ready;
    assign in_ready = advance && !clearing;
    logic acc;
    assign acc = in_valid && in_ready;

    // stage 1: differences
    logic s1_v_reg;
    logic [11:0] s1_idx_reg;
    logic [24:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [24:0] dx, dy, dz;
    assign dx = 25'(in_data.vertex_x) - 25'(hit_x_reg);
    assign dy = 25'(in_data.vertex_y) - 25'(hit_y_reg);
    assign dz = 25'(in_data.vertex_z) - 25'(hit_z_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg <= acc;
        end
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_idx_reg <= in_data.vertex_index;
            s1_dx_reg <= dx[24] ? 25'(-dx) : 25'(dx);
            s1_dy_reg <= dy[24] ? 25'(-dy) : 25'(dy);
            s1_dz_reg <= dz[24] ? 25'(-dz) : 25'(dz);
        end
    end

    // stage 2: squares
    logic s2_v_reg;
    logic [11:0] s2_idx_reg;
    logic [49:0] s2_sx_reg, s2_sy_reg, s2_sz_reg;
    logic [45:0] s2_r2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_idx_reg <= s1_idx_reg;
            s2_sx_reg <= s1_dx_reg * s1_dx_reg;
            s2_sy_reg <= s1_dy_reg * s1_dy_reg;
            s2_sz_reg <= s1_dz_reg * s1_dz_reg;
            s2_r2_reg <= range_reg * range_reg;
        end
    end

    // stage 3: sum and compare
    logic s3_v_reg;
    logic [SQ_W-1:0] len2;
    logic [SQ_W-1:0] s3_len2_reg;
    logic [11:0] s3_idx_reg;
    logic s3_hit_reg;
    assign len2 = SQ_W'(s2_sx_reg) + SQ_W'(s2_sy_reg) + SQ_W'(s2_sz_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_idx_reg <= s2_idx_reg;
            s3_len2_reg <= len2;
            s3_hit_reg <= len2 < SQ_W'(s2_r2_reg);
        end
    end

    // square root
    logic sq_v;
    logic [SQ_W/2-1:0] root;
    logic [TAG_W-1:0] sq_tag;
    vws_isqrt #(
        .IN_W(SQ_W),
        .TAG_W(TAG_W)
    ) u_isqrt (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s3_v_reg),
        .in_value(s3_len2_reg),
        .in_tag({s3_hit_reg, s3_idx_reg}),
        .advance(advance),
        .out_valid(sq_v),
        .out_root(root),
        .out_tag(sq_tag)
    );

    // stage 4: increment product, memory read issued
    logic s4_v_reg, s4_hit_reg;
    logic [11:0] s4_idx_reg;
    logic [54:0] s4_prod_reg;
    logic [22:0] rd;
    assign rd = range_reg - root[22:0];
    logic [16:0] mem [MAX_VERTS];
    logic [16:0] rd_data_reg;
    logic [AW-1:0] sq_addr;
    assign sq_addr = sq_tag[AW-1:0];
    logic s5_v_reg, s5_hit_reg;
    logic [11:0] s5_idx_reg;
    logic [16:0] s5_wet_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_v_reg <= sq_v;
        end
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_idx_reg <= sq_tag[11:0];
            s4_hit_reg <= sq_tag[12];
            s4_prod_reg <= rd * inv_reg;
            rd_data_reg <= (s5_v_reg && s5_hit_reg && s5_idx_reg[AW-1:0] == sq_addr)
                ? s5_wet_reg : mem[sq_addr];
        end
    end

    // stage 5: add with forwarding from stage 5 write-back
    logic [16:0] old_wet, inc, new_wet;
    logic [17:0] sum;
    assign old_wet = (s5_v_reg && s5_hit_reg && s5_idx_reg[AW-1:0] == s4_idx_reg[AW-1:0])
        ? s5_wet_reg : rd_data_reg;
    assign inc = (s4_prod_reg[54:16] > 39'(vws_pkg::WET_ONE)) ? vws_pkg::WET_ONE
        : s4_prod_reg[32:16];
    assign sum = 18'(old_wet) + 18'(inc);
    assign new_wet = !s4_hit_reg ? old_wet
        : (sum > 18'(vws_pkg::WET_ONE)) ? vws_pkg::WET_ONE : sum[16:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s5_v_reg <= s4_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_idx_reg <= s4_idx_reg;
            s5_hit_reg <= s4_hit_reg;
            s5_wet_reg <= new_wet;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_cnt_reg[AW-1:0]] <= '0;
        end
        else if (advance && s5_v_reg && s5_hit_reg)
        begin
            mem[s5_idx_reg[AW-1:0]] <= s5_wet_reg;
        end
    end

    // stage 6: shade product
    logic s6_v_reg;
    logic [11:0] s6_idx_reg;
    logic [16:0] s6_wet_reg;
    logic [33:0] s6_p_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s6_v_reg <= s5_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_idx_reg <= s5_idx_reg;
            s6_wet_reg <= s5_wet_reg;
            s6_p_reg <= s5_wet_reg * intensity_reg;
        end
    end

    // stage 7: output register
    logic [14:0] dark;
    logic signed [15:0] shade;
    vws_pkg::vws_out_t out_reg;
    assign dark = 15'((35'(s6_p_reg) + 35'((1 << 20) - 1)) >> 20);
    assign shade = 16'(vws_pkg::SHADE_ONE) - 16'(dark);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s7_valid_reg <= s6_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_index <= s6_idx_reg;
            out_reg.wetness_level <= s6_wet_reg;
            out_reg.shade_level <= (shade < $signed({3'b000, min_color_reg}))
                ? min_color_reg : shade[12:0];
        end
    end

    assign out_valid = s7_valid_reg;
    assign out_data = out_reg;

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("request taken during clearing pass");
    a_wet_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.wetness_level <= vws_pkg::WET_ONE)
        else $error("wetness above one");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

endmodule

// ===== tb/vws_checker.sv =====
// vws_checker: watches the request, result and register ports of vertex_wetness_splat,
// predicts each result from its own wetness store and register copy, and counts mismatches
// depends on vws_pkg
`timescale 1ns / 1ps
module vws_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  vws_pkg::vws_in_t                   in_data,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  vws_pkg::vws_out_t                  out_data,
    input  logic                               cfg_we,
    input  logic [vws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vws_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 pending,
    output int                                 errors
);
    logic signed [23:0] hit_x, hit_y, hit_z;
    logic        [22:0] splash_range;
    logic        [31:0] inverse_range;
    logic        [12:0] min_color;
    logic        [16:0] intensity;
    logic        [16:0] wetness [0:vws_pkg::MAX_VERTS-1];
    vws_pkg::vws_out_t  shade_queue [$];

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic vws_pkg::vws_out_t splat_vertex(vws_pkg::vws_in_t v);
        longint dx, dy, dz, len2, r2, root, inc, sum, prod, dark;
        int shade;
        logic [16:0] wet;
        vws_pkg::vws_out_t r;
        dx = longint'(v.vertex_x) - longint'(hit_x);
        dy = longint'(v.vertex_y) - longint'(hit_y);
        dz = longint'(v.vertex_z) - longint'(hit_z);
        len2 = dx * dx + dy * dy + dz * dz;
        r2 = longint'(splash_range) * longint'(splash_range);
        wet = wetness[v.vertex_index];
        if (len2 < r2)
        begin
            root = longint'(floor_sqrt(len2));
            inc = ((longint'(splash_range) - root) * longint'(inverse_range)) >>> 16;
            if (inc > longint'(vws_pkg::WET_ONE))
                inc = longint'(vws_pkg::WET_ONE);
            sum = longint'(wet) + inc;
            wet = (sum > longint'(vws_pkg::WET_ONE)) ? vws_pkg::WET_ONE : sum[16:0];
            wetness[v.vertex_index] = wet;
        end
        prod = longint'(wet) * longint'(intensity);
        dark = (prod + (64'd1 << 20) - 1) >>> 20;
        shade = int'(vws_pkg::SHADE_ONE) - int'(dark);
        if (shade < int'(min_color))
            shade = int'(min_color);
        r.out_index = v.vertex_index;
        r.wetness_level = wet;
        r.shade_level = shade[12:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vws_pkg::vws_out_t want;
        if (!rst_n)
        begin
            hit_x = '0;
            hit_y = '0;
            hit_z = '0;
            splash_range = 23'd256;
            inverse_range = 32'd16777216;
            min_color = 13'd409;
            intensity = 17'd32768;
            for (int i = 0; i < vws_pkg::MAX_VERTS; i++)
                wetness[i] = '0;
            shade_queue.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    vws_pkg::REG_HIT_X:     hit_x = cfg_data[23:0];
                    vws_pkg::REG_HIT_Y:     hit_y = cfg_data[23:0];
                    vws_pkg::REG_HIT_Z:     hit_z = cfg_data[23:0];
                    vws_pkg::REG_RANGE:     splash_range = cfg_data[22:0];
                    vws_pkg::REG_INV_RANGE: inverse_range = cfg_data;
                    vws_pkg::REG_MIN_COLOR: min_color = cfg_data[12:0];
                    vws_pkg::REG_INTENSITY: intensity = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                shade_queue.push_back(splat_vertex(in_data));
            if (out_valid && out_ready)
            begin
                if (shade_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result idx %0d wet %0d shade %0d", $time,
                             out_data.out_index, out_data.wetness_level, out_data.shade_level);
                end
                else
                begin
                    want = shade_queue.pop_front();
                    if (want.out_index !== out_data.out_index)
                    begin
                        errors++;
                        $display("%0t: out_index expected %0d actual %0d", $time,
                                 want.out_index, out_data.out_index);
                    end
                    if (want.wetness_level !== out_data.wetness_level)
                    begin
                        errors++;
                        $display("%0t: wetness_level idx %0d expected %0d actual %0d", $time,
                                 want.out_index, want.wetness_level, out_data.wetness_level);
                    end
                    if (want.shade_level !== out_data.shade_level)
                    begin
                        errors++;
                        $display("%0t: shade_level idx %0d expected %0d actual %0d", $time,
                                 want.out_index, want.shade_level, out_data.shade_level);
                    end
                end
            end
        end
        pending = shade_queue.size();
    end

endmodule

// ===== tb/vertex_wetness_splat_test.sv =====
// vertex_wetness_splat_test: drives vertex requests and register settings into
// vertex_wetness_splat and gives the verdict; depends on vws_pkg, vws_checker and vertex_wetness_splat
`timescale 1ns / 1ps
module vertex_wetness_splat_test;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int LIMIT = 300000;
    localparam int PHASE_ITEMS = 280;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    vws_pkg::vws_in_t in_data;
    logic out_valid;
    logic out_ready;
    vws_pkg::vws_out_t out_data;
    logic cfg_we;
    logic [vws_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vws_pkg::CFG_DATA_W-1:0] cfg_data;
    int pending;
    int errors;
    int cycles;
    int sent;

    int cur_hx, cur_hy, cur_hz, cur_range;

    vertex_wetness_splat uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vws_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("** vertex_wetness_splat: FAILED **");
            $finish;
        end
    end

    // receiver: long hold-off once, a calm stretch, otherwise random stalls
    initial
    begin
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!held && sent >= 400)
            begin
                held = 1'b1;
                hold = 400;
                out_ready <= 1'b0;
            end
            else if (cycles >= 9000 && cycles < 11000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_vertex(vws_pkg::vws_in_t v);
        if (!(sent >= 700 && sent < 1000))
            while ($urandom_range(0, 99) < 35)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_data <= v;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic apply_setting(int hx, int hy, int hz, int rng, logic [31:0] inv,
                                 int minc, int inten);
        cfg_write(vws_pkg::REG_HIT_X, hx);
        cfg_write(vws_pkg::REG_HIT_Y, hy);
        cfg_write(vws_pkg::REG_HIT_Z, hz);
        cfg_write(vws_pkg::REG_RANGE, rng);
        cfg_write(vws_pkg::REG_INV_RANGE, inv);
        cfg_write(vws_pkg::REG_MIN_COLOR, minc);
        cfg_write(vws_pkg::REG_INTENSITY, inten);
        cur_hx = hx;
        cur_hy = hy;
        cur_hz = hz;
        cur_range = rng;
    endtask

    function automatic logic [31:0] recip(int rng);
        longint q;
        if (rng <= 1)
            return 32'hFFFF_FFFF;
        q = (64'd1 << 32) / rng;
        return q[31:0];
    endfunction

    function automatic logic [23:0] near_coord(int center);
        int span;
        span = cur_range + cur_range / 4 + 2;
        if (span > 4000000)
            span = 4000000;
        return 24'(center + $urandom_range(0, 2 * span) - span);
    endfunction

    function automatic vws_pkg::vws_in_t random_vertex();
        vws_pkg::vws_in_t v;
        v.vertex_index = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 31))
                                                     : 12'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            v.vertex_x = 24'($urandom);
            v.vertex_y = 24'($urandom);
            v.vertex_z = 24'($urandom);
        end
        else
        begin
            v.vertex_x = near_coord(cur_hx);
            v.vertex_y = near_coord(cur_hy);
            v.vertex_z = near_coord(cur_hz);
        end
        return v;
    endfunction

    task automatic run_random(int n);
        repeat (n) push_vertex(random_vertex());
    endtask

    function automatic vws_pkg::vws_in_t mk(int idx, int x, int y, int z);
        vws_pkg::vws_in_t v;
        v.vertex_index = 12'(idx);
        v.vertex_x = 24'(x);
        v.vertex_y = 24'(y);
        v.vertex_z = 24'(z);
        return v;
    endfunction

    initial
    begin
        int rng;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent = 0;
        cur_hx = 0;
        cur_hy = 0;
        cur_hz = 0;
        cur_range = 256;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings
        push_vertex(mk(0, 0, 0, 0));
        push_vertex(mk(0, 0, 0, 0));
        push_vertex(mk(4095, 255, 0, 0));
        push_vertex(mk(4095, 255, 0, 0));
        push_vertex(mk(7, 256, 0, 0));
        push_vertex(mk(8, 0, -256, 0));
        push_vertex(mk(9, 0, 0, 147));
        push_vertex(mk(10, 8388607, 8388607, 8388607));
        push_vertex(mk(11, -8388608, -8388608, -8388608));
        push_vertex(mk(2048, 100, -100, 100));
        push_vertex(mk(1, 1, 1, 1));
        push_vertex(mk(4095, -1, -1, -1));
        push_vertex(mk(12, 200, 0, 0));
        drain();
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        push_vertex(mk(13, 10, 0, 0));
        drain();
        apply_setting(100, -200, 300, 512, recip(512), 0, 65536);
        push_vertex(mk(5, 100, -200, 300));
        push_vertex(mk(6, 612, -200, 300));
        push_vertex(mk(6, 611, -200, 300));
        run_random(PHASE_ITEMS);
        drain();

        apply_setting(8388607, -8388608, 8388607, 8388607, 32'd0, 4096, 0);
        push_vertex(mk(3, 8388607, -8388608, 8388607));
        push_vertex(mk(3, -8388608, 8388607, -8388608));
        run_random(PHASE_ITEMS);
        drain();

        apply_setting($urandom_range(0, 2000) - 1000, 0, -5000, 1, 32'hFFFF_FFFF,
                      8191, 131071);
        push_vertex(mk(4, cur_hx, cur_hy, cur_hz));
        run_random(PHASE_ITEMS);
        drain();

        apply_setting(0, 0, 0, 0, 32'hFFFF_FFFF, 300, 100000);
        push_vertex(mk(0, 0, 0, 0));
        run_random(80);
        drain();

        apply_setting(int'($urandom_range(0, 20000)) - 10000, 7000,
                      int'($urandom_range(0, 20000)) - 10000, 2000, recip(2000), 409, 32768);
        run_random(PHASE_ITEMS);
        drain();

        apply_setting(-8388608, 8388607, 0, 8388607, recip(8388607), 0, 65536);
        run_random(PHASE_ITEMS);
        drain();

        repeat (3)
        begin
            rng = $urandom_range(1, 100000);
            apply_setting(int'(24'($urandom)) - 8388608, int'($urandom_range(0, 8000000)),
                          int'($urandom_range(0, 8000000)) - 4000000, rng,
                          ($urandom_range(0, 1) == 0) ? recip(rng) : $urandom,
                          $urandom_range(0, 8191), $urandom_range(0, 131071));
            run_random(PHASE_ITEMS / 2);
            drain();
        end

        if (errors == 0)
            $display("** vertex_wetness_splat: PASSED **");
        else
            $display("** vertex_wetness_splat: FAILED **");
        $finish;
    end

endmodule
